// ----- src/tkf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_pkg
// Shared sizes, types and codes of the top-k frequent item tracker.
// ----------------------------------------------------------------------------
package tkf_pkg;

  localparam int TOP_K        = 8;
  localparam int ITEM_ID_BITS = 16;
  localparam int COUNT_BITS   = 32;

  localparam int TABLE_DEPTH = 2 ** ITEM_ID_BITS;
  localparam int FILL_BITS   = $clog2(TOP_K + 1);
  localparam int IDX_BITS    = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  // fixed field widths of the ports
  localparam int IN_ID_BITS     = 16;
  localparam int RANK_BITS      = 3;
  localparam int OUT_ITEM_BITS  = 16;
  localparam int OUT_COUNT_BITS = 32;
  localparam int OUT_DATA_BITS  = 56;
  localparam int K_REG_BITS     = 4;
  localparam int IVL_BITS       = 32;
  localparam int CFG_DATA_BITS  = 32;

  typedef logic [ITEM_ID_BITS-1:0] item_id_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [FILL_BITS-1:0]    fill_t;
  typedef logic [IDX_BITS-1:0]     idx_t;

  typedef struct packed {
    count_t   count;
    item_id_t id;
  } entry_t;

  // configuration register indexes
  typedef enum logic {
    REG_ACTIVE_K = 1'b0,
    REG_INTERVAL = 1'b1
  } cfg_idx_t;

  // input kinds
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_TRIM,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic   upd;
    logic   trim;
    fill_t  k;
    entry_t ent;
  } list_ctrl_t;

  typedef struct packed {
    fill_t fill;
    fill_t fill_next;
  } list_stat_t;

endpackage

// ----- src/tkf_count_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_count_ram
// Per-identifier event count memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tkf_count_ram (
  input  logic             clk,
  input  logic             we,
  input  tkf_pkg::item_id_t waddr,
  input  tkf_pkg::count_t   wdata,
  input  tkf_pkg::item_id_t raddr,
  output tkf_pkg::count_t   rdata
);

  tkf_pkg::count_t mem [tkf_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tkf_top_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_top_list
// Top list kept sorted ascending by (count, id); update, trim and report read.
// ----------------------------------------------------------------------------
module tkf_top_list (
  input  logic                clk,
  input  logic                rst,
  input  tkf_pkg::list_ctrl_t ctrl,
  input  tkf_pkg::idx_t       rd_idx,
  output tkf_pkg::entry_t     rd_entry,
  output tkf_pkg::list_stat_t stat
);

  localparam tkf_pkg::fill_t NONE = tkf_pkg::FILL_BITS'(tkf_pkg::TOP_K);

  function automatic logic entry_less(tkf_pkg::entry_t a, tkf_pkg::entry_t b);
    return (a.count < b.count) || ((a.count == b.count) && (a.id < b.id));
  endfunction

  tkf_pkg::entry_t list     [tkf_pkg::TOP_K];
  tkf_pkg::entry_t list_next[tkf_pkg::TOP_K];
  tkf_pkg::entry_t pad      [tkf_pkg::TOP_K+1];
  tkf_pkg::fill_t  fill;
  tkf_pkg::fill_t  fill_next;

  logic [tkf_pkg::TOP_K-1:0] below;
  logic                      found;
  logic                      ins;
  tkf_pkg::fill_t            f;
  tkf_pkg::fill_t            r;
  tkf_pkg::fill_t            p;

  always_comb begin
    for (int i = 0; i < tkf_pkg::TOP_K; i++) begin
      pad[i] = list[i];
    end
    pad[tkf_pkg::TOP_K] = '0;

    found = 1'b0;
    f     = '0;
    for (int i = 0; i < tkf_pkg::TOP_K; i++) begin
      if ((tkf_pkg::FILL_BITS'(i) < fill) && (list[i].id == ctrl.ent.id)) begin
        found = 1'b1;
        f     = tkf_pkg::FILL_BITS'(i);
      end
    end

    // pick the slot that leaves the list, if any
    ins = 1'b1;
    r   = NONE;
    if (found) begin
      r = f;
    end else if (fill < ctrl.k) begin
      r = NONE;
    end else if (ctrl.ent.count > list[0].count) begin
      r = '0;
    end else begin
      ins = 1'b0;
    end

    for (int i = 0; i < tkf_pkg::TOP_K; i++) begin
      below[i] = (tkf_pkg::FILL_BITS'(i) < fill) && (tkf_pkg::FILL_BITS'(i) != r) &&
                 entry_less(list[i], ctrl.ent);
    end
    p = tkf_pkg::FILL_BITS'($countones(below));

    for (int j = 0; j < tkf_pkg::TOP_K; j++) begin
      list_next[j] = list[j];
    end
    fill_next = fill;

    if (ctrl.upd && ins) begin
      for (int j = 0; j < tkf_pkg::TOP_K; j++) begin
        if (tkf_pkg::FILL_BITS'(j) == p) begin
          list_next[j] = ctrl.ent;
        end else if (tkf_pkg::FILL_BITS'(j) < p) begin
          list_next[j] = (tkf_pkg::FILL_BITS'(j) < r) ? pad[j] : pad[j+1];
        end else if (j > 0) begin
          list_next[j] = (tkf_pkg::FILL_BITS'(j-1) < r) ? pad[j-1] : pad[j];
        end
      end
      fill_next = (r == NONE) ? fill + tkf_pkg::FILL_BITS'(1) : fill;
    end else if (ctrl.trim) begin
      // drop the smallest entry
      for (int j = 0; j < tkf_pkg::TOP_K; j++) begin
        list_next[j] = pad[j+1];
      end
      fill_next = fill - tkf_pkg::FILL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < tkf_pkg::TOP_K; j++) begin
      list[j] <= list_next[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  assign rd_entry       = list[rd_idx];
  assign stat.fill      = fill;
  assign stat.fill_next = fill_next;

endmodule

// ----- src/top_k_frequent_item_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_frequent_item_tracker
// Counts events per item identifier and reports the most frequent ones.
//
// Channel  Direction  Signals                         Content
// s_       in         s_tvalid s_tready s_tdata s_tuser  item_id / kind
// m_       out        m_tvalid m_tready m_tdata m_tlast  rank, top_item, top_count / last
// cfg      in         wr_en wr_addr wr_data              active_k, report_interval
//
// After reset a clearing pass zeroes all 2^ITEM_ID_BITS (65536) entries of
// the count memory, one entry a cycle, with s_tready low. A tick is handled
// in the idle state. An event passes through a count memory read, then
// increment, write back and top list update. After active_k shrinks, the
// next event is followed by a trim step that drops the smallest entries until
// the list fits. A report holds the input while it sends each entry, also
// while m_tready stays low; the last entry waits in the output register while
// the next transaction is taken.
// ----------------------------------------------------------------------------
module top_k_frequent_item_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tkf_pkg::IN_ID_BITS-1:0]      s_tdata,  // [15:0] item_id
  input  logic                                s_tuser,  // [0] kind
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tkf_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // [2:0] rank, [18:3] top_item,
                                                        // [50:19] top_count
  output logic                                m_tlast,
  input  logic                                wr_en,
  input  tkf_pkg::cfg_idx_t                   wr_addr,
  input  logic [tkf_pkg::CFG_DATA_BITS-1:0]   wr_data
);

  tkf_pkg::state_t state;
  tkf_pkg::state_t state_next;

  logic [tkf_pkg::K_REG_BITS-1:0] active_k;
  logic [tkf_pkg::IVL_BITS-1:0]   report_interval;
  logic [tkf_pkg::IVL_BITS-1:0]   elapsed;
  logic [tkf_pkg::IVL_BITS-1:0]   elapsed_next;
  tkf_pkg::item_id_t              clr;
  tkf_pkg::item_id_t              clr_next;
  tkf_pkg::item_id_t              id_q;
  tkf_pkg::idx_t                  rptr;
  tkf_pkg::idx_t                  rptr_next;
  tkf_pkg::fill_t                 k_eff;

  logic                           s_accept;
  logic                           ram_we;
  tkf_pkg::item_id_t              ram_waddr;
  tkf_pkg::count_t                ram_wdata;
  tkf_pkg::count_t                ram_rdata;
  tkf_pkg::count_t                cnt;

  tkf_pkg::list_ctrl_t            list_ctrl;
  tkf_pkg::list_stat_t            list_stat;
  tkf_pkg::entry_t                rd_entry;

  logic                           out_load;
  logic                           out_last;
  logic                           m_valid;
  logic [tkf_pkg::OUT_DATA_BITS-1:0] m_data;
  logic                           m_last;

  assign s_tready = (state == tkf_pkg::ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_k        <= tkf_pkg::K_REG_BITS'(3);
      report_interval <= tkf_pkg::IVL_BITS'(600);
    end else if (wr_en) begin
      case (wr_addr)
        tkf_pkg::REG_ACTIVE_K: active_k        <= wr_data[tkf_pkg::K_REG_BITS-1:0];
        tkf_pkg::REG_INTERVAL: report_interval <= wr_data[tkf_pkg::IVL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (active_k == '0) begin
      k_eff = tkf_pkg::FILL_BITS'(1);
    end else if (int'(active_k) > tkf_pkg::TOP_K) begin
      k_eff = tkf_pkg::FILL_BITS'(tkf_pkg::TOP_K);
    end else begin
      k_eff = tkf_pkg::FILL_BITS'(active_k);
    end
  end

  // saturating increment of the stored count
  assign cnt = (ram_rdata == '1) ? ram_rdata : ram_rdata + tkf_pkg::COUNT_BITS'(1);

  tkf_count_ram u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (tkf_pkg::ITEM_ID_BITS'(s_tdata)),
    .rdata (ram_rdata)
  );

  tkf_top_list u_top_list (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (list_ctrl),
    .rd_idx   (rptr),
    .rd_entry (rd_entry),
    .stat     (list_stat)
  );

  always_comb begin
    state_next         = state;
    elapsed_next       = elapsed;
    clr_next           = clr;
    rptr_next          = rptr;
    ram_we             = 1'b0;
    ram_waddr          = id_q;
    ram_wdata          = cnt;
    list_ctrl.upd      = 1'b0;
    list_ctrl.trim     = 1'b0;
    list_ctrl.k        = k_eff;
    list_ctrl.ent.count = cnt;
    list_ctrl.ent.id   = id_q;
    out_load           = 1'b0;
    out_last           = (tkf_pkg::FILL_BITS'(rptr) == list_stat.fill - tkf_pkg::FILL_BITS'(1));

    case (state)
      tkf_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
        clr_next  = clr + tkf_pkg::ITEM_ID_BITS'(1);
        if (clr == '1) begin
          state_next = tkf_pkg::ST_IDLE;
        end
      end
      tkf_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (s_tuser == tkf_pkg::KIND_TICK) begin
            if (elapsed != '1) begin
              elapsed_next = elapsed + tkf_pkg::IVL_BITS'(1);
            end
          end else begin
            state_next = tkf_pkg::ST_UPDATE;
          end
        end
      end
      tkf_pkg::ST_UPDATE: begin
        ram_we        = 1'b1;
        list_ctrl.upd = 1'b1;
        if (list_stat.fill_next > k_eff) begin
          state_next = tkf_pkg::ST_TRIM;
        end else if (elapsed >= report_interval) begin
          elapsed_next = '0;
          rptr_next    = '0;
          state_next   = tkf_pkg::ST_REPORT;
        end else begin
          state_next = tkf_pkg::ST_IDLE;
        end
      end
      tkf_pkg::ST_TRIM: begin
        if (list_stat.fill > k_eff) begin
          list_ctrl.trim = 1'b1;
        end else if (elapsed >= report_interval) begin
          elapsed_next = '0;
          rptr_next    = '0;
          state_next   = tkf_pkg::ST_REPORT;
        end else begin
          state_next = tkf_pkg::ST_IDLE;
        end
      end
      tkf_pkg::ST_REPORT: begin
        if (!m_valid || m_tready) begin
          out_load  = 1'b1;
          rptr_next = rptr + tkf_pkg::IDX_BITS'(1);
          if (out_last) begin
            state_next = tkf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = tkf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tkf_pkg::ST_CLEAR;
      elapsed <= '0;
      clr     <= '0;
      rptr    <= '0;
    end else begin
      state   <= state_next;
      elapsed <= elapsed_next;
      clr     <= clr_next;
      rptr    <= rptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && (s_tuser == tkf_pkg::KIND_EVENT)) begin
      id_q <= tkf_pkg::ITEM_ID_BITS'(s_tdata);
    end
  end

  // output register: hold the entry until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_load) begin
      m_valid <= 1'b1;
    end else if (m_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_data <= {5'b0,
                 tkf_pkg::OUT_COUNT_BITS'(rd_entry.count),
                 tkf_pkg::OUT_ITEM_BITS'(rd_entry.id),
                 tkf_pkg::RANK_BITS'(rptr)};
      m_last <= out_last;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = m_data;
  assign m_tlast  = m_last;

  a_reset_clears : assert property (@(posedge clk) rst |=> state == tkf_pkg::ST_CLEAR)
    else $error("reset did not start the clearing pass");

  a_tick_stays_idle : assert property (@(posedge clk) disable iff (rst)
    (s_accept && (s_tuser == tkf_pkg::KIND_TICK)) |=> state == tkf_pkg::ST_IDLE)
    else $error("tick left the idle state");

  a_update_one_cycle : assert property (@(posedge clk) disable iff (rst)
    (state == tkf_pkg::ST_UPDATE) |=> (state != tkf_pkg::ST_UPDATE))
    else $error("update lasted more than one cycle");

  a_report_nonempty : assert property (@(posedge clk) disable iff (rst)
    (state == tkf_pkg::ST_REPORT) |-> (list_stat.fill != '0))
    else $error("report started on an empty list");

  a_fill_bounded : assert property (@(posedge clk) disable iff (rst)
    list_stat.fill <= tkf_pkg::FILL_BITS'(tkf_pkg::TOP_K))
    else $error("top list overfilled");

endmodule
